// ===== rtl/core/scomp_pkg.sv =====
`default_nettype none

package scomp_pkg;

   localparam int SCOMP_LINE_WIDTH = 256;
   localparam int SCOMP_LINE_MAX = 1024;
   localparam int PIXEL_X_W = 8;
   localparam int WRAP_ENTRY_W = $clog2(SCOMP_LINE_MAX);
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int MATH_W = 17;

   localparam logic [2:0] SRC_BACKDROP = 3'd6;
   localparam logic [MATH_W-1:0] LOW_BITS = 17'h00421;
   localparam logic [MATH_W-1:0] CARRY_BITS = 17'h08420;
   localparam logic [MATH_W-1:0] HALF_MASK = 17'h07bde;

   typedef enum logic [1:0] {
      CMD_CLEAR     = 2'd0,
      CMD_PLOT_MAIN = 2'd1,
      CMD_PLOT_SUB  = 2'd2,
      CMD_EMIT      = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_BRIGHTNESS   = 3'd0,
      REG_FIXED_COLOR  = 3'd1,
      REG_BACKDROP     = 3'd2,
      REG_MATH_MASK    = 3'd3,
      REG_SUB_BLEND    = 3'd4,
      REG_SUBTRACT     = 3'd5,
      REG_HALVE        = 3'd6,
      REG_HIRES        = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_EMIT2
   } state_type;

   typedef struct packed {
      logic [2:0]  src;
      logic [3:0]  prio;
      logic [14:0] color;
   } entry_type;

   typedef struct packed {
      logic [3:0]  brightness;
      logic [14:0] fixed_color;
      logic [14:0] backdrop_color;
      logic [6:0]  math_source_mask;
      logic        subscreen_blend;
      logic        subtract_mode;
      logic        halve_enable;
      logic        hires;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic fetch;
      logic update;
      logic emit;
      logic swap;
      logic last;
   } ctl_type;

   typedef struct packed {
      cmd_type op;
      logic    hires;
   } status_type;

   typedef logic [(1 << PIXEL_X_W)-1:0][WRAP_ENTRY_W-1:0] wrap_table_type;

   function automatic wrap_table_type x_wrap_table(input int width);
      wrap_table_type t;
      int r;
      r = 0;
      for (int i = 0; i < (1 << PIXEL_X_W); i++) begin
         t[i] = WRAP_ENTRY_W'(r);
         r = (r + 1 == width) ? 0 : r + 1;
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scanline_priority_compositor_unit.sv =====
`default_nettype none

// Scanline priority compositor with color math.
// Command channel: an item is taken at a clock edge with start high and busy
// low. cmd selects clear entry, plot main, plot sub or emit pixel at pixel_x
// (taken modulo LINE_WIDTH). Clear and plot give no result; emit gives one
// beat on the rsp_ ports, or two in hires mode, last set on the final beat.
// Each result beat is shown for one cycle with rsp_valid high; the receiver
// cannot stall it.
// ST_FETCH reads the line entries, ST_EXEC updates them or composes the
// result beat, and a hires emit adds ST_EMIT2 for the second beat; no new
// item is taken until idle. The rate is set by the single read/write port
// of each line memory (read, then write back). Configuration goes through
// the csr_ APB port at byte address 4*index and must be written only while
// busy is low and no result is pending; the block does not enforce it.
// Reset clears the controller and all configuration registers to zero; the
// line memories are not cleared, so each entry must be cleared before use.
module scanline_priority_compositor_unit
   import scomp_pkg::*;
#(
   parameter int LINE_WIDTH = SCOMP_LINE_WIDTH
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [PIXEL_X_W-1:0]  req_pixel_x,
   input  wire logic [2:0]            req_layer_source,
   input  wire logic [3:0]            req_layer_priority,
   input  wire logic [14:0]           req_layer_color,
   input  wire logic                  req_main_window,
   input  wire logic                  req_sub_window,
   output      logic                  rsp_valid,
   output      logic [14:0]           rsp_pixel_color,
   output      logic [3:0]            rsp_brightness_level,
   output      logic                  rsp_last,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   cfg_type    cfg;
   ctl_type    ctl;
   status_type status;

   scomp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   scomp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .ctl    (ctl)
   );

   scomp_dpath #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (ctl),
      .status               (status),
      .cfg                  (cfg),
      .req_cmd              (req_cmd),
      .req_pixel_x          (req_pixel_x),
      .req_layer_source     (req_layer_source),
      .req_layer_priority   (req_layer_priority),
      .req_layer_color      (req_layer_color),
      .req_main_window      (req_main_window),
      .req_sub_window       (req_sub_window),
      .rsp_valid            (rsp_valid),
      .rsp_pixel_color      (rsp_pixel_color),
      .rsp_brightness_level (rsp_brightness_level),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/scomp_csr.sv =====
`default_nettype none

module scomp_csr
   import scomp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index = reg_index_type'(csr_paddr[4:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_BRIGHTNESS: cfg_in.brightness = csr_pwdata[3:0];
            REG_FIXED_COLOR: cfg_in.fixed_color = csr_pwdata[14:0];
            REG_BACKDROP: cfg_in.backdrop_color = csr_pwdata[14:0];
            REG_MATH_MASK: cfg_in.math_source_mask = csr_pwdata[6:0];
            REG_SUB_BLEND: cfg_in.subscreen_blend = csr_pwdata[0];
            REG_SUBTRACT: cfg_in.subtract_mode = csr_pwdata[0];
            REG_HALVE: cfg_in.halve_enable = csr_pwdata[0];
            REG_HIRES: cfg_in.hires = csr_pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         REG_BRIGHTNESS: csr_prdata = CSR_DATA_W'(cfg_ff.brightness);
         REG_FIXED_COLOR: csr_prdata = CSR_DATA_W'(cfg_ff.fixed_color);
         REG_BACKDROP: csr_prdata = CSR_DATA_W'(cfg_ff.backdrop_color);
         REG_MATH_MASK: csr_prdata = CSR_DATA_W'(cfg_ff.math_source_mask);
         REG_SUB_BLEND: csr_prdata = CSR_DATA_W'(cfg_ff.subscreen_blend);
         REG_SUBTRACT: csr_prdata = CSR_DATA_W'(cfg_ff.subtract_mode);
         REG_HALVE: csr_prdata = CSR_DATA_W'(cfg_ff.halve_enable);
         REG_HIRES: csr_prdata = CSR_DATA_W'(cfg_ff.hires);
         default: csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/scomp_ctrl.sv =====
`default_nettype none

module scomp_ctrl
   import scomp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output      logic       busy,
   input  wire status_type status,
   output      ctl_type    ctl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl.load = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            ctl.fetch = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.op == CMD_EMIT) begin
               ctl.emit = 1'b1;
               ctl.swap = status.hires;
               ctl.last = !status.hires;
               state_in = status.hires ? ST_EMIT2 : ST_IDLE;
            end else begin
               ctl.update = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT2: begin
            ctl.emit = 1'b1;
            ctl.last = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.load, ctl.fetch, ctl.update, ctl.emit}))
      else $error("more than one datapath command at once");

   a_load_fetch: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> ctl.fetch)
      else $error("load not followed by fetch");

   a_second_beat: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit && ctl.swap) |=> (ctl.emit && ctl.last && !ctl.swap))
      else $error("hires emit missing its second beat");

   a_no_update_on_emit: assert property (@(posedge clock) disable iff (reset)
      ctl.update |-> status.op != CMD_EMIT)
      else $error("line update issued for an emit");

endmodule

`default_nettype wire

// ===== rtl/core/scomp_dpath.sv =====
`default_nettype none

module scomp_dpath
   import scomp_pkg::*;
#(
   parameter int LINE_WIDTH = SCOMP_LINE_WIDTH
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctl_type              ctl,
   output      status_type           status,
   input  wire cfg_type              cfg,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [PIXEL_X_W-1:0] req_pixel_x,
   input  wire logic [2:0]           req_layer_source,
   input  wire logic [3:0]           req_layer_priority,
   input  wire logic [14:0]          req_layer_color,
   input  wire logic                 req_main_window,
   input  wire logic                 req_sub_window,
   output      logic                 rsp_valid,
   output      logic [14:0]          rsp_pixel_color,
   output      logic [3:0]           rsp_brightness_level,
   output      logic                 rsp_last
);

   localparam int ADDR_W = $clog2(LINE_WIDTH);
   localparam wrap_table_type WRAP = x_wrap_table(LINE_WIDTH);

   entry_type main_mem [LINE_WIDTH];
   entry_type sub_mem [LINE_WIDTH];

   cmd_type           op_ff;
   logic [ADDR_W-1:0] x_ff;
   entry_type         item_ff;
   logic              mw_ff;
   logic              sw_ff;
   entry_type         main_rd_ff;
   entry_type         sub_rd_ff;
   logic              rsp_valid_ff;
   logic [14:0]       rsp_color_ff;
   logic [3:0]        rsp_bright_ff;
   logic              rsp_last_ff;

   entry_type main_clr;
   entry_type sub_clr;
   logic      main_we;
   logic      sub_we;
   entry_type main_wdata;
   entry_type sub_wdata;
   entry_type top;
   entry_type bot;
   logic [7:0]  mask_ext;
   logic [14:0] base_color;
   logic [14:0] operand;
   logic        halve;
   logic [14:0] composed;

   function automatic logic [14:0] color_mix(input logic [14:0] a, input logic [14:0] b,
                                             input logic sub, input logic halve_on);
      logic [MATH_W-1:0] ax;
      logic [MATH_W-1:0] bx;
      logic [MATH_W-1:0] sum;
      logic [MATH_W-1:0] carry;
      logic [MATH_W-1:0] diff;
      logic [MATH_W-1:0] borrow;
      logic [MATH_W-1:0] r;
      ax = MATH_W'(a);
      bx = MATH_W'(b);
      sum = ax + bx;
      carry = (sum - ((ax ^ bx) & LOW_BITS)) & CARRY_BITS;
      diff = ax + CARRY_BITS - bx;
      borrow = (diff - ((ax ^ bx) & CARRY_BITS)) & CARRY_BITS;
      if (!sub) begin
         if (!halve_on) begin
            r = (sum - carry) | (carry - (carry >> 5));
         end else begin
            r = (sum - ((ax ^ bx) & LOW_BITS)) >> 1;
         end
      end else begin
         r = (diff - borrow) & (borrow - (borrow >> 5));
         if (halve_on) begin
            r = (r & HALF_MASK) >> 1;
         end
      end
      return r[14:0];
   endfunction

   assign status.op = op_ff;
   assign status.hires = cfg.hires;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         op_ff <= cmd_type'(req_cmd);
         x_ff <= WRAP[req_pixel_x][ADDR_W-1:0];
         item_ff.src <= req_layer_source;
         item_ff.prio <= req_layer_priority;
         item_ff.color <= req_layer_color;
         mw_ff <= req_main_window;
         sw_ff <= req_sub_window;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fetch) begin
         main_rd_ff <= main_mem[x_ff];
         sub_rd_ff <= sub_mem[x_ff];
      end
   end

   always_comb begin
      main_clr = '{src: SRC_BACKDROP, prio: 4'd0, color: cfg.backdrop_color};
      sub_clr = '{src: SRC_BACKDROP, prio: 4'd0,
                  color: cfg.hires ? cfg.backdrop_color : cfg.fixed_color};
      main_we = 1'b0;
      sub_we = 1'b0;
      main_wdata = item_ff;
      sub_wdata = item_ff;
      if (ctl.update) begin
         case (op_ff)
            CMD_CLEAR: begin
               main_we = 1'b1;
               sub_we = 1'b1;
               main_wdata = main_clr;
               sub_wdata = sub_clr;
            end
            CMD_PLOT_MAIN: main_we = item_ff.prio > main_rd_ff.prio;
            CMD_PLOT_SUB: sub_we = item_ff.prio > sub_rd_ff.prio;
            default: begin
               main_we = 1'b0;
               sub_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (main_we) begin
         main_mem[x_ff] <= main_wdata;
      end
      if (sub_we) begin
         sub_mem[x_ff] <= sub_wdata;
      end
   end

   always_comb begin
      top = ctl.swap ? sub_rd_ff : main_rd_ff;
      bot = ctl.swap ? main_rd_ff : sub_rd_ff;
      mask_ext = {1'b0, cfg.math_source_mask};
      base_color = mw_ff ? top.color : 15'd0;
      operand = cfg.subscreen_blend ? bot.color : cfg.fixed_color;
      halve = cfg.halve_enable && mw_ff && (!cfg.subscreen_blend || bot.src != SRC_BACKDROP);
      if (sw_ff && mask_ext[top.src]) begin
         composed = color_mix(base_color, operand, cfg.subtract_mode, halve);
      end else begin
         composed = base_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_color_ff <= composed;
         rsp_bright_ff <= cfg.brightness;
         rsp_last_ff <= ctl.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_brightness_level = rsp_bright_ff;
   assign rsp_last = rsp_last_ff;

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> (rsp_valid && rsp_last))
      else $error("first hires beat not followed by the last beat");

endmodule

`default_nettype wire

// ===== dv/scanline_priority_compositor_unit_tb.sv =====
`default_nettype none

module scanline_priority_compositor_unit_tb;
   import scomp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_GUARD = 500;
   localparam int ITEMS_PER_SETTING = 86;

   typedef struct {
      cmd_type     cmd;
      logic [7:0]  x;
      logic [2:0]  src;
      logic [3:0]  prio;
      logic [14:0] color;
      logic        mw;
      logic        sw;
   } pixel_cmd_t;

   typedef struct {
      logic [14:0] color;
      logic [3:0]  level;
      logic        last;
   } pixel_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_cmd = '0;
   logic [PIXEL_X_W-1:0] req_pixel_x = '0;
   logic [2:0] req_layer_source = '0;
   logic [3:0] req_layer_priority = '0;
   logic [14:0] req_layer_color = '0;
   logic req_main_window = 1'b0;
   logic req_sub_window = 1'b0;
   logic rsp_valid;
   logic [14:0] rsp_pixel_color;
   logic [3:0] rsp_brightness_level;
   logic rsp_last;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   scanline_priority_compositor_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_pixel_x(req_pixel_x),
      .req_layer_source(req_layer_source),
      .req_layer_priority(req_layer_priority),
      .req_layer_color(req_layer_color),
      .req_main_window(req_main_window),
      .req_sub_window(req_sub_window),
      .rsp_valid(rsp_valid),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_brightness_level(rsp_brightness_level),
      .rsp_last(rsp_last),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   cfg_type active_cfg = '0;
   entry_type main_buf [SCOMP_LINE_WIDTH];
   entry_type sub_buf [SCOMP_LINE_WIDTH];
   bit entry_valid [SCOMP_LINE_WIDTH];
   pixel_beat_t pending_pixels [$];
   pixel_beat_t front_pixel;

   int gap_max = 0;
   int cmd_count = 0;
   int emit_count = 0;
   int beat_count = 0;
   int setting_count = 0;
   int fail_count = 0;
   int cycle_count = 0;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel beat with no pending expectation");
            fail_count++;
         end else begin
            front_pixel = pending_pixels.pop_front();
            beat_count++;
            if (rsp_pixel_color !== front_pixel.color) begin
               $error("pixel_color expected %h actual %h", front_pixel.color, rsp_pixel_color);
               fail_count++;
            end
            if (rsp_brightness_level !== front_pixel.level) begin
               $error("brightness_level expected %h actual %h",
                      front_pixel.level, rsp_brightness_level);
               fail_count++;
            end
            if (rsp_last !== front_pixel.last) begin
               $error("last expected %b actual %b", front_pixel.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [14:0] blend_color(input logic [14:0] a, input logic [14:0] b,
                                               input logic halve);
      logic [14:0] r;
      int ca;
      int cb;
      int v;
      r = '0;
      for (int ch = 0; ch < 3; ch++) begin
         ca = int'(a[ch*5 +: 5]);
         cb = int'(b[ch*5 +: 5]);
         if (active_cfg.subtract_mode) begin
            v = ca - cb;
            if (v < 0) v = 0;
            if (halve) v = v >> 1;
         end else begin
            v = ca + cb;
            if (halve) v = v >> 1;
            else if (v > 31) v = 31;
         end
         r[ch*5 +: 5] = v[4:0];
      end
      return r;
   endfunction

   function automatic logic [14:0] compose_pixel(input entry_type top, input entry_type bot,
                                                 input logic mw, input logic sw);
      logic [14:0] c;
      c = mw ? top.color : 15'd0;
      if (!sw || top.src == 3'd7 || !active_cfg.math_source_mask[top.src])
         return c;
      if (!active_cfg.subscreen_blend)
         return blend_color(c, active_cfg.fixed_color, active_cfg.halve_enable && mw);
      return blend_color(c, bot.color,
                         active_cfg.halve_enable && mw && bot.src != SRC_BACKDROP);
   endfunction

   task automatic predict_pixels(input pixel_cmd_t c);
      pixel_beat_t b;
      b.level = active_cfg.brightness;
      case (c.cmd)
         CMD_CLEAR: begin
            main_buf[c.x] = '{src: SRC_BACKDROP, prio: 4'd0, color: active_cfg.backdrop_color};
            sub_buf[c.x] = '{src: SRC_BACKDROP, prio: 4'd0,
                             color: active_cfg.hires ? active_cfg.backdrop_color
                                                     : active_cfg.fixed_color};
            entry_valid[c.x] = 1'b1;
         end
         CMD_PLOT_MAIN: begin
            if (c.prio > main_buf[c.x].prio)
               main_buf[c.x] = '{src: c.src, prio: c.prio, color: c.color};
         end
         CMD_PLOT_SUB: begin
            if (c.prio > sub_buf[c.x].prio)
               sub_buf[c.x] = '{src: c.src, prio: c.prio, color: c.color};
         end
         default: begin
            emit_count++;
            if (active_cfg.hires) begin
               b.color = compose_pixel(sub_buf[c.x], main_buf[c.x], c.mw, c.sw);
               b.last = 1'b0;
               pending_pixels.push_back(b);
            end
            b.color = compose_pixel(main_buf[c.x], sub_buf[c.x], c.mw, c.sw);
            b.last = 1'b1;
            pending_pixels.push_back(b);
         end
      endcase
   endtask

   task automatic send_cmd(input pixel_cmd_t c);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= c.cmd;
      req_pixel_x <= c.x;
      req_layer_source <= c.src;
      req_layer_priority <= c.prio;
      req_layer_color <= c.color;
      req_main_window <= c.mw;
      req_sub_window <= c.sw;
      do @(posedge clock); while (busy);
      cmd_count++;
      predict_pixels(c);
   endtask

   task automatic wait_idle();
      int guard;
      start <= 1'b0;
      guard = 0;
      while (pending_pixels.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_BRIGHTNESS:  active_cfg.brightness = value[3:0];
         REG_FIXED_COLOR: active_cfg.fixed_color = value[14:0];
         REG_BACKDROP:    active_cfg.backdrop_color = value[14:0];
         REG_MATH_MASK:   active_cfg.math_source_mask = value[6:0];
         REG_SUB_BLEND:   active_cfg.subscreen_blend = value[0];
         REG_SUBTRACT:    active_cfg.subtract_mode = value[0];
         REG_HALVE:       active_cfg.halve_enable = value[0];
         default:         active_cfg.hires = value[0];
      endcase
      @(posedge clock);
   endtask

   task automatic load_settings(input cfg_type c);
      wait_idle();
      write_reg(REG_BRIGHTNESS, 32'(c.brightness));
      write_reg(REG_FIXED_COLOR, 32'(c.fixed_color));
      write_reg(REG_BACKDROP, 32'(c.backdrop_color));
      write_reg(REG_MATH_MASK, 32'(c.math_source_mask));
      write_reg(REG_SUB_BLEND, 32'(c.subscreen_blend));
      write_reg(REG_SUBTRACT, 32'(c.subtract_mode));
      write_reg(REG_HALVE, 32'(c.halve_enable));
      write_reg(REG_HIRES, 32'(c.hires));
      setting_count++;
   endtask

   function automatic pixel_cmd_t rand_cmd(input cmd_type op, input logic [7:0] x);
      pixel_cmd_t c;
      c.cmd = op;
      c.x = x;
      c.src = 3'($urandom_range(0, 7));
      c.prio = 4'($urandom_range(0, 15));
      c.color = 15'($urandom);
      c.mw = $urandom_range(0, 3) != 0;
      c.sw = $urandom_range(0, 3) != 0;
      return c;
   endfunction

   task automatic send_plot(input cmd_type op, input logic [7:0] x, input logic [2:0] src,
                            input logic [3:0] prio, input logic [14:0] color);
      pixel_cmd_t c;
      c = rand_cmd(op, x);
      c.src = src;
      c.prio = prio;
      c.color = color;
      send_cmd(c);
   endtask

   task automatic send_emit(input logic [7:0] x, input logic mw, input logic sw);
      pixel_cmd_t c;
      c = rand_cmd(CMD_EMIT, x);
      c.mw = mw;
      c.sw = sw;
      send_cmd(c);
   endtask

   task automatic test_reset_values();
      gap_max = 0;
      send_cmd(rand_cmd(CMD_CLEAR, 8'd0));
      send_emit(8'd0, 1'b1, 1'b1);
   endtask

   task automatic test_corner_cases();
      cfg_type c;
      c = '{brightness: 4'hf, fixed_color: 15'h7fff, backdrop_color: 15'h1234,
            math_source_mask: 7'h7f, subscreen_blend: 1'b1, subtract_mode: 1'b0,
            halve_enable: 1'b1, hires: 1'b0};
      load_settings(c);
      gap_max = 3;
      send_cmd(rand_cmd(CMD_CLEAR, 8'd0));
      send_cmd(rand_cmd(CMD_CLEAR, 8'd255));
      send_emit(8'd0, 1'b1, 1'b1);
      send_plot(CMD_PLOT_MAIN, 8'd0, 3'd0, 4'd15, 15'h7fff);
      send_plot(CMD_PLOT_SUB, 8'd0, 3'd5, 4'd15, 15'h7fff);
      send_emit(8'd0, 1'b1, 1'b1);
      send_plot(CMD_PLOT_MAIN, 8'd0, 3'd1, 4'd15, 15'h0000);
      send_plot(CMD_PLOT_MAIN, 8'd0, 3'd2, 4'd3, 15'h0000);
      send_emit(8'd0, 1'b0, 1'b1);
      send_emit(8'd0, 1'b1, 1'b0);
      send_emit(8'd0, 1'b0, 1'b0);
      send_plot(CMD_PLOT_MAIN, 8'd255, 3'd7, 4'd1, 15'h001f);
      send_emit(8'd255, 1'b1, 1'b1);
      send_plot(CMD_PLOT_SUB, 8'd255, 3'd4, 4'd15, 15'h7c1f);
      send_emit(8'd255, 1'b1, 1'b1);
      c.subtract_mode = 1'b1;
      c.hires = 1'b1;
      c.brightness = 4'h0;
      load_settings(c);
      send_cmd(rand_cmd(CMD_CLEAR, 8'd128));
      send_plot(CMD_PLOT_MAIN, 8'd128, 3'd1, 4'd8, 15'h0421);
      send_plot(CMD_PLOT_SUB, 8'd128, 3'd2, 4'd9, 15'h7fff);
      send_emit(8'd128, 1'b1, 1'b1);
      send_emit(8'd128, 1'b1, 1'b0);
      send_cmd(rand_cmd(CMD_CLEAR, 8'd127));
      send_emit(8'd127, 1'b1, 1'b1);
   endtask

   task automatic run_random_items(input int count);
      int stop_at;
      int pause_at;
      int plots;
      logic [7:0] x;
      pixel_cmd_t c;
      stop_at = cmd_count + count;
      pause_at = cmd_count + count / 2;
      while (cmd_count < stop_at) begin
         if (cmd_count >= pause_at) begin
            wait_idle();
            pause_at = stop_at;
         end
         x = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 3) != 0) begin
            if (!entry_valid[x] || $urandom_range(0, 2) != 0)
               send_cmd(rand_cmd(CMD_CLEAR, x));
            plots = $urandom_range(0, 4);
            repeat (plots)
               send_cmd(rand_cmd($urandom_range(0, 1) ? CMD_PLOT_MAIN : CMD_PLOT_SUB, x));
            send_cmd(rand_cmd(CMD_EMIT, x));
         end else begin
            c = rand_cmd(cmd_type'($urandom_range(0, 3)), x);
            if (!entry_valid[x]) c.cmd = CMD_CLEAR;
            send_cmd(c);
         end
      end
   endtask

   task automatic test_register_settings();
      cfg_type c;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: c = '0;
            1: c = '{brightness: 4'hf, fixed_color: 15'h7fff, backdrop_color: 15'h7fff,
                     math_source_mask: 7'h7f, subscreen_blend: 1'b1, subtract_mode: 1'b1,
                     halve_enable: 1'b1, hires: 1'b1};
            2: begin
               c = cfg_type'(45'({$urandom, $urandom}));
               c.math_source_mask = 7'h7f;
               c.subscreen_blend = 1'b1;
               c.subtract_mode = 1'b0;
            end
            default: c = cfg_type'(45'({$urandom, $urandom}));
         endcase
         load_settings(c);
         gap_max = (phase % 2 == 0) ? 15 : 0;
         run_random_items(ITEMS_PER_SETTING);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_corner_cases();
      test_register_settings();
      wait_idle();
      if (pending_pixels.size() != 0) begin
         $error("%0d pixel beats never arrived", pending_pixels.size());
         fail_count++;
      end
      $display("Sent %0d commands (%0d emits) under %0d register settings, idle and busy",
               cmd_count, emit_count, setting_count);
      $display("Checked %0d pixel beats, %0d mismatches", beat_count, fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== scanline_priority_compositor_unit.f =====
rtl/core/scomp_pkg.sv
rtl/core/scomp_csr.sv
rtl/core/scomp_ctrl.sv
rtl/core/scomp_dpath.sv
rtl/core/scanline_priority_compositor_unit.sv
dv/scanline_priority_compositor_unit_tb.sv
